>>> hw/rtl/indexed_list_engine_assert.svh
// Assertion macros for the indexed list engine.
// Included by the top level; the checks drop out when SYNTHESIS is defined.
`ifndef INDEXED_LIST_ENGINE_ASSERT_SVH
`define INDEXED_LIST_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define ILE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("indexed_list_engine: check failed");
// Next-cycle implication
`define ILE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("indexed_list_engine: check failed");
`else
`define ILE_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define ILE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hw/rtl/ile_pkg.sv
// Shared constants, types and codes of the indexed list engine.
// No dependencies; each RTL file but the assertion header uses it by scoped names.
`default_nettype none

package ile_pkg;

	localparam int CAPACITY  = 16;
	localparam int WORD_BITS = 32;
	localparam int IDX_BITS  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_BITS  = $clog2(CAPACITY + 1);

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [IDX_BITS-1:0]  idx_t;
	typedef logic [CNT_BITS-1:0]  cnt_t;

	// Fixed field widths of the command and result beats
	typedef logic [4:0]  pos_t;
	typedef logic [31:0] oword_t;
	typedef logic [3:0]  found_t;
	typedef logic [4:0]  entries_t;

	typedef enum logic [2:0] {
		OP_APPEND   = 3'd0,
		OP_INSERT   = 3'd1,
		OP_READ     = 3'd2,
		OP_POP      = 3'd3,
		OP_POP_LAST = 3'd4,
		OP_REMOVE   = 3'd5,
		OP_FIND     = 3'd6,
		OP_REVERSE  = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_RANGE = 2'd2,
		STAT_MISS  = 2'd3
	} stat_t;

	// Action broadcast to every cell of the row
	typedef enum logic [2:0] {
		ACT_HOLD,
		ACT_INSERT,
		ACT_DELETE,
		ACT_TAG,
		ACT_SWAP
	} cell_act_t;

	typedef struct packed {
		cell_act_t act;
		cnt_t      pos;
		logic      odd;
	} cell_ctl_t;

	typedef struct packed {
		logic any;
		idx_t first;
	} match_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_EXEC,
		FSM_REV,
		FSM_WRAP
	} fsm_t;

	typedef struct packed {
		op_t   op;
		pos_t  pos;
		word_t word;
	} cmd_t;

	typedef struct packed {
		stat_t    status;
		oword_t   word;
		found_t   found;
		entries_t entries;
	} res_t;

endpackage

`default_nettype wire

>>> hw/rtl/ile_intf.sv
// Handshake interfaces for the command and result channels.
// Depends on ile_pkg for the opcode and status codes.
`default_nettype none

interface ile_cmd_if;
	logic              valid;
	logic              ready;
	ile_pkg::op_t      opcode;
	ile_pkg::pos_t     position;
	logic [31:0]       word_in;

	modport source (output valid, output opcode, output position, output word_in,
		input ready);
	modport sink (input valid, input opcode, input position, input word_in,
		output ready);
endinterface

interface ile_res_if;
	logic              valid;
	logic              ready;
	ile_pkg::stat_t    status;
	logic [31:0]       word_out;
	logic [3:0]        found_at;
	logic [4:0]        entries;

	modport source (output valid, output status, output word_out, output found_at,
		output entries, input ready);
	modport sink (input valid, input status, input word_out, input found_at,
		input entries, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/indexed_list_engine.sv
// Top level of the indexed list engine: command sequencer, count, result
// register. Depends on ile_pkg, ile_intf and ile_chain.
`default_nettype none
`include "indexed_list_engine_assert.svh"

// An ordered list of up to CAPACITY words kept in a row of cells, each cell
// holding one entry and trading data with its neighbours. A command beat is
// taken while the sequencer is idle and carried out in its execute state once
// the output register is free, for append, insert, read, pop, pop last,
// remove and find alike; no new command is accepted until the last is done.
// Reverse runs an odd-even transposition pass over the row, one pass per
// live entry when it holds two or more entries and none otherwise; the number
// of passes is what sets its length. A finished result waits in the output
// register and only holds the sequencer when the next result is due while
// the previous one has not yet been taken. Every command gives one result
// beat with status, word, match index and the count after the command.
module indexed_list_engine (
	input  wire logic clk,
	input  wire logic arst_n,
	ile_cmd_if.sink   cmd,
	ile_res_if.source res
);

	ile_pkg::fsm_t      state_q, state_n;
	ile_pkg::cmd_t      cmd_q;
	ile_pkg::cnt_t      fill_q, fill_n;
	ile_pkg::cnt_t      phase_q;
	logic               out_valid_q;
	ile_pkg::res_t      res_q, res_n;
	logic               res_load;
	logic               exec_fire;
	logic               out_free;
	ile_pkg::cell_act_t act_c;
	ile_pkg::cnt_t      pos_c;
	ile_pkg::cell_ctl_t ctl;
	ile_pkg::idx_t      sel_idx;
	ile_pkg::match_t    match;
	ile_pkg::word_t     sel_word;

	assign out_free  = !out_valid_q || res.ready;
	assign cmd.ready = (state_q == ile_pkg::FSM_IDLE);
	assign ctl       = '{act: act_c, pos: pos_c, odd: phase_q[0]};

	ile_chain u_chain (
		.clk      (clk),
		.ctl      (ctl),
		.key      (cmd_q.word),
		.fill     (fill_q),
		.sel_idx  (sel_idx),
		.match    (match),
		.sel_word (sel_word)
	);

	// Capture the command beat
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_q <= '{op: cmd.opcode, pos: cmd.position,
				word: ile_pkg::word_t'(cmd.word_in)};
		end
	end

	// Point the entry select at the cell the command reads
	always_comb begin
		sel_idx = ile_pkg::idx_t'(cmd_q.pos);
		if (cmd_q.op == ile_pkg::OP_POP_LAST) begin
			sel_idx = ile_pkg::idx_t'(fill_q - 1'b1);
		end else if (cmd_q.op == ile_pkg::OP_REMOVE) begin
			sel_idx = match.first;
		end
	end

	// Next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ile_pkg::FSM_IDLE: begin
				if (cmd.valid) begin
					state_n = ile_pkg::FSM_EXEC;
				end
			end
			ile_pkg::FSM_EXEC: begin
				if (cmd_q.op == ile_pkg::OP_REVERSE) begin
					state_n = (fill_q >= 2'd2) ? ile_pkg::FSM_REV : ile_pkg::FSM_WRAP;
				end else if (out_free) begin
					state_n = ile_pkg::FSM_IDLE;
				end
			end
			ile_pkg::FSM_REV: begin
				if (phase_q + 1'b1 == fill_q) begin
					state_n = ile_pkg::FSM_WRAP;
				end
			end
			ile_pkg::FSM_WRAP: begin
				if (out_free) begin
					state_n = ile_pkg::FSM_IDLE;
				end
			end
			default: state_n = ile_pkg::FSM_IDLE;
		endcase
	end

	// Decode the command into a row action, a new count and a result
	always_comb begin
		act_c     = ile_pkg::ACT_HOLD;
		pos_c     = '0;
		fill_n    = fill_q;
		res_load  = 1'b0;
		exec_fire = 1'b0;
		res_n     = '{status: ile_pkg::STAT_OK, word: '0, found: '0,
			entries: ile_pkg::entries_t'(fill_q)};
		unique case (state_q)
			ile_pkg::FSM_IDLE: begin
			end
			ile_pkg::FSM_EXEC: begin
				if (cmd_q.op == ile_pkg::OP_REVERSE) begin
					act_c = ile_pkg::ACT_TAG;
				end else if (out_free) begin
					exec_fire = 1'b1;
					res_load  = 1'b1;
					unique case (cmd_q.op)
						ile_pkg::OP_APPEND: begin
							if (fill_q == ile_pkg::cnt_t'(ile_pkg::CAPACITY)) begin
								res_n.status = ile_pkg::STAT_FULL;
							end else begin
								act_c  = ile_pkg::ACT_INSERT;
								pos_c  = fill_q;
								fill_n = fill_q + 1'b1;
							end
						end
						ile_pkg::OP_INSERT: begin
							if (cmd_q.pos > fill_q) begin
								res_n.status = ile_pkg::STAT_RANGE;
							end else if (fill_q == ile_pkg::cnt_t'(ile_pkg::CAPACITY)) begin
								res_n.status = ile_pkg::STAT_FULL;
							end else begin
								act_c  = ile_pkg::ACT_INSERT;
								pos_c  = ile_pkg::cnt_t'(cmd_q.pos);
								fill_n = fill_q + 1'b1;
							end
						end
						ile_pkg::OP_READ: begin
							if (cmd_q.pos >= fill_q) begin
								res_n.status = ile_pkg::STAT_RANGE;
							end else begin
								res_n.word = ile_pkg::oword_t'(sel_word);
							end
						end
						ile_pkg::OP_POP: begin
							if (cmd_q.pos >= fill_q) begin
								res_n.status = ile_pkg::STAT_RANGE;
							end else begin
								res_n.word = ile_pkg::oword_t'(sel_word);
								act_c      = ile_pkg::ACT_DELETE;
								pos_c      = ile_pkg::cnt_t'(cmd_q.pos);
								fill_n     = fill_q - 1'b1;
							end
						end
						ile_pkg::OP_POP_LAST: begin
							if (fill_q == '0) begin
								res_n.status = ile_pkg::STAT_MISS;
							end else begin
								res_n.word = ile_pkg::oword_t'(sel_word);
								fill_n     = fill_q - 1'b1;
							end
						end
						ile_pkg::OP_REMOVE: begin
							if (!match.any) begin
								res_n.status = ile_pkg::STAT_MISS;
							end else begin
								res_n.word  = ile_pkg::oword_t'(sel_word);
								res_n.found = ile_pkg::found_t'(match.first);
								act_c       = ile_pkg::ACT_DELETE;
								pos_c       = ile_pkg::cnt_t'(match.first);
								fill_n      = fill_q - 1'b1;
							end
						end
						ile_pkg::OP_FIND: begin
							if (!match.any) begin
								res_n.status = ile_pkg::STAT_MISS;
							end else begin
								res_n.found = ile_pkg::found_t'(match.first);
							end
						end
						ile_pkg::OP_REVERSE: begin
							// handled by the tag and swap passes
						end
						default: begin
						end
					endcase
					res_n.entries = ile_pkg::entries_t'(fill_n);
				end
			end
			ile_pkg::FSM_REV: begin
				act_c = ile_pkg::ACT_SWAP;
			end
			ile_pkg::FSM_WRAP: begin
				res_load = out_free;
			end
			default: begin
			end
		endcase
	end

	// Advance the sequencer and the count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ile_pkg::FSM_IDLE;
			fill_q  <= '0;
		end else begin
			state_q <= state_n;
			fill_q  <= fill_n;
		end
	end

	// Count the swap passes of a reverse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (state_q == ile_pkg::FSM_EXEC) begin
			phase_q <= '0;
		end else if (state_q == ile_pkg::FSM_REV) begin
			phase_q <= phase_q + 1'b1;
		end
	end

	// Hold the result beat until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res_n;
		end
	end

	assign res.valid    = out_valid_q;
	assign res.status   = res_q.status;
	assign res.word_out = res_q.word;
	assign res.found_at = res_q.found;
	assign res.entries  = res_q.entries;

	// Checks
	`ILE_ASSERT_NOW(a_fill_bound, clk, arst_n, 1'b1, fill_q <= ile_pkg::cnt_t'(ile_pkg::CAPACITY))
	`ILE_ASSERT_NEXT(a_fill_hold, clk, arst_n, !exec_fire, $stable(fill_q))
	`ILE_ASSERT_NOW(a_word_zero, clk, arst_n, res_load && (res_n.status != ile_pkg::STAT_OK), res_n.word == '0)
	`ILE_ASSERT_NOW(a_phase_range, clk, arst_n, state_q == ile_pkg::FSM_REV, phase_q < fill_q)

endmodule

`default_nettype wire

>>> hw/rtl/ile_cell.sv
// One cell of the list row: holds one entry and its reverse-sort tag.
// Depends on ile_pkg; takes data from its lower or upper neighbour.
`default_nettype none

module ile_cell (
	input  wire logic              clk,
	input  wire ile_pkg::idx_t     idx,
	input  wire ile_pkg::cell_ctl_t ctl,
	input  wire ile_pkg::word_t    key,
	input  wire ile_pkg::cnt_t     fill,
	input  wire ile_pkg::word_t    lower_word,
	input  wire ile_pkg::idx_t     lower_tag,
	input  wire ile_pkg::word_t    upper_word,
	input  wire ile_pkg::idx_t     upper_tag,
	output      ile_pkg::word_t    word,
	output      ile_pkg::idx_t     tag,
	output      logic              hit
);

	ile_pkg::word_t word_q, word_n;
	ile_pkg::idx_t  tag_q, tag_n;
	ile_pkg::cnt_t  at_c;
	logic           left_c;

	assign at_c   = ile_pkg::cnt_t'(idx);
	assign left_c = (idx[0] == ctl.odd);

	// Flag a live entry that equals the search key
	assign hit = (at_c < fill) && (word_q == key);

	// Pick the next content of this cell
	always_comb begin
		word_n = word_q;
		tag_n  = tag_q;
		case (ctl.act)
			ile_pkg::ACT_INSERT: begin
				if (at_c == ctl.pos) begin
					word_n = key;
				end else if (at_c > ctl.pos) begin
					word_n = lower_word;
				end
			end
			ile_pkg::ACT_DELETE: begin
				if (at_c >= ctl.pos) begin
					word_n = upper_word;
				end
			end
			ile_pkg::ACT_TAG: begin
				tag_n = idx;
			end
			ile_pkg::ACT_SWAP: begin
				// Odd-even transposition: swap a pair whose tags are still ascending
				if (left_c) begin
					if ((at_c + 1'b1 < fill) && (tag_q < upper_tag)) begin
						word_n = upper_word;
						tag_n  = upper_tag;
					end
				end else begin
					if ((at_c != '0) && (at_c < fill) && (lower_tag < tag_q)) begin
						word_n = lower_word;
						tag_n  = lower_tag;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Hold the entry
	always_ff @(posedge clk) begin
		word_q <= word_n;
		tag_q  <= tag_n;
	end

	assign word = word_q;
	assign tag  = tag_q;

endmodule

`default_nettype wire

>>> hw/rtl/ile_chain.sv
// Row of list cells wired neighbour to neighbour, with the first-match
// encoder and the entry select. Depends on ile_pkg and ile_cell.
`default_nettype none

module ile_chain (
	input  wire logic               clk,
	input  wire ile_pkg::cell_ctl_t ctl,
	input  wire ile_pkg::word_t     key,
	input  wire ile_pkg::cnt_t      fill,
	input  wire ile_pkg::idx_t      sel_idx,
	output      ile_pkg::match_t    match,
	output      ile_pkg::word_t     sel_word
);

	ile_pkg::word_t              word_c [ile_pkg::CAPACITY];
	ile_pkg::idx_t               tag_c  [ile_pkg::CAPACITY];
	logic [ile_pkg::CAPACITY-1:0] hit_c;

	// Build the row; the ends see their own content as neighbour
	for (genvar g = 0; g < ile_pkg::CAPACITY; g++) begin : g_cell
		ile_pkg::word_t lower_w, upper_w;
		ile_pkg::idx_t  lower_t, upper_t;

		if (g == 0) begin : g_bot
			assign lower_w = word_c[g];
			assign lower_t = tag_c[g];
		end else begin : g_mid_lo
			assign lower_w = word_c[g-1];
			assign lower_t = tag_c[g-1];
		end

		if (g == ile_pkg::CAPACITY - 1) begin : g_top
			assign upper_w = word_c[g];
			assign upper_t = tag_c[g];
		end else begin : g_mid_hi
			assign upper_w = word_c[g+1];
			assign upper_t = tag_c[g+1];
		end

		ile_cell u_cell (
			.clk        (clk),
			.idx        (ile_pkg::idx_t'(g)),
			.ctl        (ctl),
			.key        (key),
			.fill       (fill),
			.lower_word (lower_w),
			.lower_tag  (lower_t),
			.upper_word (upper_w),
			.upper_tag  (upper_t),
			.word       (word_c[g]),
			.tag        (tag_c[g]),
			.hit        (hit_c[g])
		);
	end

	// Encode the lowest matching cell
	always_comb begin
		match = '{any: 1'b0, first: '0};
		for (int i = ile_pkg::CAPACITY - 1; i >= 0; i--) begin
			if (hit_c[i]) begin
				match.any   = 1'b1;
				match.first = ile_pkg::idx_t'(i);
			end
		end
	end

	// Select one entry for read, pop, pop last and remove
	always_comb begin
		sel_word = '0;
		for (int i = 0; i < ile_pkg::CAPACITY; i++) begin
			if (ile_pkg::idx_t'(i) == sel_idx) begin
				sel_word = word_c[i];
			end
		end
	end

endmodule

`default_nettype wire
